/* sv/tlar_pkg.sv */
// Shared package of the antialiased track line rasterizer.
// Holds widths, register index codes, controller states and the command and
// status structs between controller and datapath. Depends on nothing.
package tlar_pkg;

  localparam int MAX_TRACK_WIDTH = 7;
  localparam int COORD_BITS      = 12;

  // Width of the clamped segment length
  localparam int WB  = $clog2(MAX_TRACK_WIDTH + 1);
  // Q.16 coordinates, integer pixel coordinates, gradient
  localparam int CW  = 34;
  localparam int EW  = 18;
  localparam int GW  = 18;
  // slope * width
  localparam int DW  = 20 + WB + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_SPACING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SPACING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKS_GROUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd5;

  // Steep gradient is floor(2^32 / |slope|) < 2^16: one quotient bit a step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_PREP, ST_DIV, ST_GRAD,
    ST_EP0, ST_EP1, ST_INT, ST_MUL1, ST_MUL2, ST_OUT
  } state_e;

  typedef enum logic [1:0] {PH_EP0, PH_EP1, PH_INT} phase_e;

  typedef struct packed {
    logic load_item;
    logic setup;
    logic prep;
    logic div_step;
    logic grad_load;
    logic ep_load;
    logic ep_sel;
    logic int_load;
    logic mul1;
    logic sub;
    logic mul2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic steep;
    logic more_int;
    logic out_free;
  } status_t;

endpackage

/* sv/tlar_in_if.sv */
// Input channel of the rasterizer: one pressure sample per transaction.
// Depends on nothing.
interface tlar_in_if;
  logic               valid;
  logic               ready;
  logic               line_start;
  logic [11:0]        start_x;
  logic signed [21:0] start_y;
  logic [15:0]        pressure;

  modport source (output valid, line_start, start_x, start_y, pressure, input ready);
  modport sink   (input valid, line_start, start_x, start_y, pressure, output ready);
endinterface

/* sv/tlar_out_if.sv */
// Output channel of the rasterizer: one shaded pixel per transaction.
// Depends on nothing.
interface tlar_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] pixel_x;
  logic signed [13:0] pixel_y;
  logic [7:0]         pixel_weight;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, pixel_weight, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_weight, last, output ready);
endinterface

/* sv/tlar_ctrl.sv */
// Controller of the rasterizer: sequences setup, gradient division, endpoint
// and interior points and the per-pixel weight steps. Depends on tlar_pkg.
module tlar_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tlar_pkg::status_t status_i,
  output tlar_pkg::cmd_t    cmd_o
);

  tlar_pkg::state_e state_q, state_d;
  tlar_pkg::phase_e phase_q, phase_d;
  logic sub_q, sub_d;
  logic [tlar_pkg::DIV_CW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlar_pkg::ST_IDLE;
      phase_q <= tlar_pkg::PH_EP0;
      sub_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    sub_d      = sub_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tlar_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = tlar_pkg::ST_SETUP;
        end
      end
      tlar_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = tlar_pkg::ST_PREP;
      end
      tlar_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        state_d = status_i.steep ? tlar_pkg::ST_DIV : tlar_pkg::ST_EP0;
      end
      tlar_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tlar_pkg::DIV_CW'(tlar_pkg::DIV_STEPS - 1)) begin
          state_d = tlar_pkg::ST_GRAD;
        end
      end
      tlar_pkg::ST_GRAD: begin
        cmd_o.grad_load = 1'b1;
        state_d = tlar_pkg::ST_EP0;
      end
      tlar_pkg::ST_EP0: begin
        cmd_o.ep_load = 1'b1;
        cmd_o.ep_sel  = 1'b0;
        phase_d = tlar_pkg::PH_EP0;
        sub_d   = 1'b0;
        state_d = tlar_pkg::ST_MUL1;
      end
      tlar_pkg::ST_EP1: begin
        cmd_o.ep_load = 1'b1;
        cmd_o.ep_sel  = 1'b1;
        phase_d = tlar_pkg::PH_EP1;
        sub_d   = 1'b0;
        state_d = tlar_pkg::ST_MUL1;
      end
      tlar_pkg::ST_INT: begin
        cmd_o.int_load = 1'b1;
        phase_d = tlar_pkg::PH_INT;
        sub_d   = 1'b0;
        state_d = tlar_pkg::ST_MUL1;
      end
      tlar_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        cmd_o.sub  = sub_q;
        state_d = tlar_pkg::ST_MUL2;
      end
      tlar_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = tlar_pkg::ST_OUT;
      end
      tlar_pkg::ST_OUT: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.steep && !sub_q) begin
            sub_d   = 1'b1;
            state_d = tlar_pkg::ST_MUL1;
          end else begin
            unique case (phase_q)
              tlar_pkg::PH_EP0: state_d = tlar_pkg::ST_EP1;
              tlar_pkg::PH_EP1,
              tlar_pkg::PH_INT: state_d = status_i.more_int ? tlar_pkg::ST_INT
                                                             : tlar_pkg::ST_IDLE;
              default:          state_d = tlar_pkg::ST_IDLE;
            endcase
          end
        end
      end
      default: state_d = tlar_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/tlar_dp.sv */
// Datapath of the rasterizer: configuration, pen state, gradient divider,
// endpoint arithmetic, weight multipliers and output register. Depends on tlar_pkg.
module tlar_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tlar_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             line_start_i,
  input  logic [11:0]                      start_x_i,
  input  logic signed [21:0]               start_y_i,
  input  logic [15:0]                      pressure_i,
  input  tlar_pkg::cmd_t                   cmd_i,
  output tlar_pkg::status_t                status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [13:0]               pixel_x_o,
  output logic signed [13:0]               pixel_y_o,
  output logic [7:0]                       pixel_weight_o,
  output logic                             last_o
);

  localparam int CW = tlar_pkg::CW;
  localparam int EW = tlar_pkg::EW;
  localparam int GW = tlar_pkg::GW;
  localparam int WB = tlar_pkg::WB;
  localparam int DW = tlar_pkg::DW;
  localparam logic [WB-1:0] WMAX = WB'(tlar_pkg::MAX_TRACK_WIDTH);
  localparam logic [11:0] XMASK = 12'((33'd1 << tlar_pkg::COORD_BITS) - 33'd1);
  localparam logic signed [19:0] SLOPE_MAX = 20'sd262144;
  localparam logic signed [19:0] SLOPE_MIN = -20'sd262144;

  // configuration
  logic signed [19:0] slope_q;
  logic [2:0]  width_q;
  logic [5:0]  tsp_q, gsp_q;
  logic [6:0]  tpg_q;
  logic [15:0] gain_q;

  // pen state
  logic [12:0]        pen_x_q;
  logic signed [23:0] pen_y_q;
  logic [5:0]         tc_q;

  // item registers
  logic [15:0]          pressure_q;
  logic [12:0]          x0_q;
  logic signed [23:0]   y0_q;
  logic [31:0]          aprod_q;
  logic [24:0]          a255_q;
  logic signed [DW-1:0] dyq_q;
  logic [WB-1:0]        w_q;
  logic                 steep_q;
  logic [18:0]          sabs_q;
  logic signed [CW-1:0] a0_q, b0_q, a1_q, b1_q;
  logic signed [GW-1:0] grad_q;
  logic [32:0]          rem_q;
  logic [33:0]          dvs_q;
  logic [15:0]          quo_q;

  // point and pixel registers
  logic signed [EW-1:0] cur_q, e1_q, pt_major_q;
  logic signed [CW-1:0] inter_q, pt_minor_q;
  logic [16:0]          pt_gap_q;
  logic                 pt_last_q;
  logic [13:0]          px_q, py_q;
  logic [33:0]          m1_q;
  logic                 plast_q;
  logic [41:0]          pl_q, ph_q;

  // output register
  logic                 out_valid_q;
  logic [13:0]          ox_q, oy_q;
  logic [7:0]           ow_q;
  logic                 olast_q;

  // configuration derived values
  logic signed [19:0] slope_c;
  logic [WB-1:0]      w_c;
  logic [6:0]         tpg_c;
  logic [6:0]         tc_next;
  logic               wrap_c;
  logic [7:0]         n_c;
  logic signed [28:0] sn_c;
  logic signed [28:0] adv_c;
  logic signed [DW-1:0] dyq_c;

  always_comb begin
    if (slope_q > SLOPE_MAX) begin
      slope_c = SLOPE_MAX;
    end else if (slope_q < SLOPE_MIN) begin
      slope_c = SLOPE_MIN;
    end else begin
      slope_c = slope_q;
    end
    if (int'(width_q) > tlar_pkg::MAX_TRACK_WIDTH) begin
      w_c = WMAX;
    end else begin
      w_c = WB'(width_q);
    end
    if (tpg_q == 7'd0) begin
      tpg_c = 7'd1;
    end else if (tpg_q > 7'd64) begin
      tpg_c = 7'd64;
    end else begin
      tpg_c = tpg_q;
    end
    tc_next = {1'b0, tc_q} + 7'd1;
    wrap_c  = tc_next >= tpg_c;
    n_c     = 8'(w_c) + (wrap_c ? {2'b0, gsp_q} : {2'b0, tsp_q});
    sn_c    = slope_c * $signed({1'b0, n_c});
    adv_c   = (sn_c + 29'sd128) >>> 8;
    dyq_c   = slope_c * $signed({1'b0, w_c});
  end

  // geometry setup
  logic signed [CW-1:0] y0s_c, dys_c, xa_c, xb_c;
  logic [16:0]          ap_c;
  logic [19:0]          apsh_c;

  always_comb begin
    y0s_c  = {{2{y0_q[23]}}, y0_q, 8'b0};
    dys_c  = CW'(dyq_q);
    xa_c   = $signed({5'b0, x0_q, 16'b0});
    xb_c   = $signed({4'b0, 14'({1'b0, x0_q} + 14'(w_q)), 16'b0});
    apsh_c = aprod_q[31:12];
    ap_c   = (apsh_c > 20'd65536) ? 17'd65536 : apsh_c[16:0];
  end

  // endpoint arithmetic
  logic signed [CW-1:0] asel_c, bsel_c, around_c, d_full_c, ye_c;
  logic signed [EW-1:0] e_c;
  logic signed [16:0]   d_c;
  logic signed [34:0]   gd_c;
  logic [15:0]          afrac_c;
  logic [16:0]          gap_c;
  logic signed [EW-1:0] cur_nx_c;

  always_comb begin
    asel_c   = cmd_i.ep_sel ? a1_q : a0_q;
    bsel_c   = cmd_i.ep_sel ? b1_q : b0_q;
    around_c = asel_c + (asel_c[CW-1] ? CW'(32767) : CW'(32768));
    e_c      = EW'(around_c >>> 16);
    d_full_c = $signed({e_c, 16'b0}) - asel_c;
    d_c      = d_full_c[16:0];
    gd_c     = grad_q * d_c;
    ye_c     = bsel_c + CW'(gd_c >>> 16);
    afrac_c  = 16'(asel_c + CW'(32768));
    gap_c    = 17'd65536 - {1'b0, afrac_c};
    cur_nx_c = cur_q + EW'(1);
  end

  // pixel selection
  logic signed [EW-1:0] fl_c, fl1_c;
  logic [16:0]          cov_c;
  logic [13:0]          px_c, py_c;
  logic [59:0]          sum_c;
  logic [11:0]          wt_c;

  always_comb begin
    fl_c  = EW'(pt_minor_q >>> 16);
    fl1_c = fl_c + EW'(1);
    cov_c = cmd_i.sub ? {1'b0, pt_minor_q[15:0]} : 17'd65536 - {1'b0, pt_minor_q[15:0]};
    if (steep_q) begin
      px_c = cmd_i.sub ? fl1_c[13:0] : fl_c[13:0];
      py_c = pt_major_q[13:0];
    end else begin
      px_c = pt_major_q[13:0];
      py_c = fl_c[13:0];
    end
    sum_c = {1'b0, ph_q, 17'b0} + 60'(pl_q) + (60'd1 << 47);
    wt_c  = sum_c[59:48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= '0;
      width_q <= 3'd4;
      tsp_q   <= 6'd3;
      gsp_q   <= 6'd6;
      tpg_q   <= 7'd6;
      gain_q  <= 16'd4096;
      pen_x_q <= '0;
      pen_y_q <= '0;
      tc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tlar_pkg::CFG_SLOPE:         slope_q <= cfg_data_i;
          tlar_pkg::CFG_TRACK_WIDTH:   width_q <= cfg_data_i[2:0];
          tlar_pkg::CFG_TRACK_SPACING: tsp_q   <= cfg_data_i[5:0];
          tlar_pkg::CFG_GROUP_SPACING: gsp_q   <= cfg_data_i[5:0];
          tlar_pkg::CFG_TRACKS_GROUP:  tpg_q   <= cfg_data_i[6:0];
          tlar_pkg::CFG_GAIN:          gain_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.load_item && line_start_i) begin
        pen_x_q <= {1'b0, start_x_i & XMASK};
        pen_y_q <= {{2{start_y_i[21]}}, start_y_i};
        tc_q    <= '0;
      end
      if (cmd_i.setup) begin
        // advance the pen for the next track
        pen_x_q <= pen_x_q + 13'(n_c);
        pen_y_q <= pen_y_q + adv_c[23:0];
        tc_q    <= wrap_c ? 6'd0 : tc_next[5:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pressure_q <= pressure_i;
    end
    if (cmd_i.setup) begin
      x0_q    <= pen_x_q;
      y0_q    <= pen_y_q;
      aprod_q <= pressure_q * gain_q;
      dyq_q   <= dyq_c;
      w_q     <= w_c;
      sabs_q  <= slope_c[19] ? 19'(-slope_c) : slope_c[18:0];
      steep_q <= (w_c != '0) &&
                 ((slope_c > 20'sd65536) || (slope_c < -20'sd65536));
    end
    if (cmd_i.prep) begin
      a255_q <= {ap_c, 8'b0} - 25'(ap_c);
      if (steep_q) begin
        if (!dyq_q[DW-1]) begin
          a0_q <= y0s_c;         b0_q <= xa_c;
          a1_q <= y0s_c + dys_c; b1_q <= xb_c;
        end else begin
          a0_q <= y0s_c + dys_c; b0_q <= xb_c;
          a1_q <= y0s_c;         b1_q <= xa_c;
        end
      end else begin
        a0_q <= xa_c; b0_q <= y0s_c;
        a1_q <= xb_c; b1_q <= y0s_c + dys_c;
      end
      grad_q <= (w_q == '0) ? GW'(65536) : GW'(slope_c);
      rem_q  <= 33'h1_0000_0000;
      dvs_q  <= {sabs_q, 15'b0};
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if ({1'b0, rem_q} >= dvs_q) begin
        rem_q <= rem_q - dvs_q[32:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        quo_q <= {quo_q[14:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.grad_load) begin
      grad_q <= dyq_q[DW-1] ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
    end
    if (cmd_i.ep_load) begin
      pt_major_q <= e_c;
      pt_minor_q <= ye_c;
      pt_gap_q   <= gap_c;
      if (!cmd_i.ep_sel) begin
        inter_q   <= ye_c + CW'(grad_q);
        cur_q     <= e_c + EW'(1);
        pt_last_q <= 1'b0;
      end else begin
        e1_q      <= e_c;
        pt_last_q <= !(cur_q < e_c);
      end
    end
    if (cmd_i.int_load) begin
      pt_major_q <= cur_q;
      pt_minor_q <= inter_q;
      pt_gap_q   <= 17'd65536;
      inter_q    <= inter_q + CW'(grad_q);
      cur_q      <= cur_nx_c;
      pt_last_q  <= !(cur_nx_c < e1_q);
    end
    if (cmd_i.mul1) begin
      px_q    <= px_c;
      py_q    <= py_c;
      m1_q    <= cov_c * pt_gap_q;
      plast_q <= pt_last_q && (!steep_q || cmd_i.sub);
    end
    if (cmd_i.mul2) begin
      pl_q <= m1_q[16:0] * a255_q;
      ph_q <= m1_q[33:17] * a255_q;
    end
    if (cmd_i.out_load) begin
      ox_q    <= px_q;
      oy_q    <= py_q;
      ow_q    <= (wt_c > 12'd255) ? 8'd255 : wt_c[7:0];
      olast_q <= plast_q;
    end
  end

  assign status_o.steep    = steep_q;
  assign status_o.more_int = cur_q < e1_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = ox_q;
  assign pixel_y_o      = oy_q;
  assign pixel_weight_o = ow_q;
  assign last_o         = olast_q;

`ifndef SYNTHESIS
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a transaction");
  a_div_steep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> steep_q)
    else $error("gradient division on a shallow segment");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grad_load |-> (rem_q < 33'(sabs_q)))
    else $error("divider remainder not below divisor");
  a_int_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.int_load |-> (cur_q < e1_q))
    else $error("interior point past the far endpoint");
`endif

endmodule

/* sv/track_line_antialias_rasterizer.sv */
// Antialiased track line rasterizer: one pressure sample in, one short
// Wu-style segment out as a stream of pixel transactions, last on the final one.
// An item is taken only while the block is idle. It passes the load, setup
// and prep states, on steep segments (|slope| above 1.0, nonzero width) the
// one-bit-per-cycle gradient divider and the gradient load, then per point a
// load and the MUL1, MUL2 and output steps of the weight multiplier chain,
// which steep rows (two pixels) run twice; the output step waits on stalls.
// Shallow segments give width+1 pixels (2 for zero width), steep ones 2 pixels
// per row. The last pixel waits in an output register while the next sample is
// accepted. Depends on tlar_pkg, tlar_in_if, tlar_out_if, tlar_ctrl and tlar_dp.
module track_line_antialias_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlar_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tlar_in_if.sink                         in_if,
  tlar_out_if.source                      out_if
);

  tlar_pkg::cmd_t    cmd;
  tlar_pkg::status_t status;

  tlar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlar_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .line_start_i   (in_if.line_start),
    .start_x_i      (in_if.start_x),
    .start_y_i      (in_if.start_y),
    .pressure_i     (in_if.pressure),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .pixel_x_o      (out_if.pixel_x),
    .pixel_y_o      (out_if.pixel_y),
    .pixel_weight_o (out_if.pixel_weight),
    .last_o         (out_if.last)
  );

endmodule
